>>> rtl/irec_pkg.sv
// Shared types and constants for the infrared raw edge capture block.
package irec_pkg;

	localparam int unsigned STORE_DEPTH_DEF = 512;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned IDX_W           = 9;
	localparam int unsigned COUNT_W         = 10;
	localparam int unsigned DATA_W          = 16;
	localparam int unsigned CFG_IDX_W       = 1;

	localparam logic [DATA_W-1:0]    MAX_GAP         = 16'hFFFF;
	localparam logic [TIME_W-1:0]    TIMEOUT_RST     = 32'd50000;
	localparam logic [COUNT_W-1:0]   MIN_EDGES_RST   = 10'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGES   = 1'b1;

	typedef enum logic [1:0] {
		REQ_EDGE   = 2'd0,
		REQ_POLL   = 2'd1,
		REQ_RESUME = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_READY     = 2'd0,
		MODE_RECEIVING = 2'd1,
		MODE_ENDED     = 2'd2,
		MODE_AVAILABLE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_SPLIT = 2'd2,
		ST_ZERO  = 2'd3
	} state_t;

endpackage

>>> rtl/irec_if.sv
// Request and response channel interfaces for the edge capture block.
interface irec_req_if
	import irec_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [TIME_W-1:0]  now_us;
	logic [IDX_W-1:0]   read_index;

	modport source (output valid, req_type, now_us, read_index, input ready);
	modport sink   (input valid, req_type, now_us, read_index, output ready);
endinterface

interface irec_rsp_if
	import irec_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         rx_status;
	logic               frame_ready;
	logic [COUNT_W-1:0] entry_count;
	logic [DATA_W-1:0]  read_data;
	logic               overflowed;

	modport source (output valid, rx_status, frame_ready, entry_count, read_data, overflowed,
		input ready);
	modport sink   (input valid, rx_status, frame_ready, entry_count, read_data, overflowed,
		output ready);
endinterface

>>> rtl/ir_raw_edge_capture_core.sv
// Infrared raw edge timing capture: sequencer around a single duration store.
//
// Usage: each req item is an edge (timestamp in now_us), a time poll, a resume or a
// read of one stored duration (read_index). Every req item yields exactly one rsp item
// carrying the mode, frame-available flag, entry count, read data and overflow flag.
// Configuration (timeout_us, min_edges) is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce.
// Sequencing: an item is taken in the idle state and executed in the exec state, and its
// result is loaded into the output register, from which it is offered. An edge while
// receiving goes on to the split state for its store write, and a gap over 0xFFFF first
// writes (0xFFFF, 0) pairs through the split and zero states, since the store has one
// write port; the pair count is bounded by half the store depth. Reads use the store's
// registered read port, issued on acceptance.
// One item is in flight at a time; a new item is taken while the previous result still
// sits in the output register, and the item stalls at its last step until that register
// drains. A stalled receiver therefore holds back at most one further item.
// Reset: mode ready, counters and flags cleared, timeout 50000 us, min_edges 8. The
// store contents are not cleared; only entries below the fill count are ever returned.
module ir_raw_edge_capture_core
	import irec_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_wdata,
	irec_req_if.sink             req,
	irec_rsp_if.source           rsp
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
	localparam int unsigned CW = (FW > IDX_W) ? FW : IDX_W;
	localparam int unsigned MW = (FW > COUNT_W) ? FW : COUNT_W;

	// configuration
	logic [TIME_W-1:0]  timeout_q;
	logic [COUNT_W-1:0] min_edges_q;

	// capture state
	state_t             state_q, state_n;
	mode_t              mode_q, mode_n;
	logic [FW-1:0]      fill_q, fill_n;
	logic               ovf_q, ovf_n;
	logic [TIME_W-1:0]  last_q, last_n;
	logic [TIME_W-1:0]  gap_q, gap_n;

	// accepted item
	req_t               req_q;
	logic [TIME_W-1:0]  now_q;
	logic [IDX_W-1:0]   idx_q;

	// store
	logic [DATA_W-1:0]  mem [STORE_DEPTH];
	logic [DATA_W-1:0]  rd_data_s1;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [DATA_W-1:0]  mem_wd;

	// result register
	logic               out_valid_q;
	mode_t              out_mode_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_ovf_q;
	logic               rsp_load;
	logic [DATA_W-1:0]  data_n;

	logic               accept;
	logic               out_free;
	logic [TIME_W-1:0]  gap_w;
	logic [FW:0]        fill_p2;
	logic               long_gap;
	logic               rd_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rd_en     = accept && (req_t'(req.req_type) == REQ_READ);
	assign rd_addr   = AW'(req.read_index);

	assign gap_w    = now_q - last_q;
	assign fill_p2  = {1'b0, fill_q} + (FW+1)'(2);
	assign long_gap = gap_q > TIME_W'(MAX_GAP);
	assign rd_hit   = CW'(idx_q) < CW'(fill_q);

	assign rsp.valid       = out_valid_q;
	assign rsp.rx_status   = out_mode_q;
	assign rsp.frame_ready = (out_mode_q == MODE_AVAILABLE);
	assign rsp.entry_count = out_count_q;
	assign rsp.read_data   = out_data_q;
	assign rsp.overflowed  = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RST;
			min_edges_q <= MIN_EDGES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT:   timeout_q   <= cfg_wdata;
				CFG_MIN_EDGES: min_edges_q <= cfg_wdata[COUNT_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		mode_n   = mode_q;
		fill_n   = fill_q;
		ovf_n    = ovf_q;
		last_n   = last_q;
		gap_n    = gap_q;
		mem_we   = 1'b0;
		mem_wa   = AW'(fill_q);
		mem_wd   = '0;
		rsp_load = 1'b0;
		data_n   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (req_q)
					REQ_EDGE: begin
						if (mode_q == MODE_RECEIVING) begin
							last_n  = now_q;
							gap_n   = gap_w;
							state_n = ST_SPLIT;
						end else if (out_free) begin
							last_n = now_q;
							if (mode_q == MODE_READY) begin
								mode_n = MODE_RECEIVING;
								fill_n = '0;
								ovf_n  = 1'b0;
							end
							rsp_load = 1'b1;
							state_n  = ST_IDLE;
						end
					end
					REQ_POLL: begin
						if (out_free) begin
							if (mode_q == MODE_RECEIVING && gap_w > timeout_q) begin
								mode_n = MODE_ENDED;
							end else if (mode_q == MODE_ENDED) begin
								mode_n = (MW'(fill_q) < MW'(min_edges_q)) ? MODE_READY
									: MODE_AVAILABLE;
							end
							rsp_load = 1'b1;
							state_n  = ST_IDLE;
						end
					end
					REQ_RESUME: begin
						if (out_free) begin
							mode_n   = MODE_READY;
							rsp_load = 1'b1;
							state_n  = ST_IDLE;
						end
					end
					REQ_READ: begin
						if (out_free) begin
							data_n   = rd_hit ? rd_data_s1 : '0;
							rsp_load = 1'b1;
							state_n  = ST_IDLE;
						end
					end
				endcase
			end
			ST_SPLIT: begin
				if (long_gap && fill_p2 <= (FW+1)'(STORE_DEPTH)) begin
					mem_we  = 1'b1;
					mem_wd  = MAX_GAP;
					fill_n  = fill_q + FW'(1);
					state_n = ST_ZERO;
				end else if (out_free) begin
					if (long_gap) ovf_n = 1'b1;
					if (fill_q >= FW'(STORE_DEPTH)) begin
						ovf_n = 1'b1;
					end else begin
						mem_we = 1'b1;
						mem_wd = long_gap ? MAX_GAP : gap_q[DATA_W-1:0];
						fill_n = fill_q + FW'(1);
					end
					rsp_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			ST_ZERO: begin
				mem_we  = 1'b1;
				mem_wd  = '0;
				fill_n  = fill_q + FW'(1);
				gap_n   = gap_q - TIME_W'(MAX_GAP);
				state_n = ST_SPLIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_READY;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_n;
			fill_q <= fill_n;
			ovf_q  <= ovf_n;
			last_q <= last_n;
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		gap_q <= gap_n;
		if (accept) begin
			req_q <= req_t'(req.req_type);
			now_q <= req.now_us;
			idx_q <= req.read_index;
		end
		if (rsp_load) begin
			out_mode_q  <= mode_n;
			out_count_q <= COUNT_W'(fill_n);
			out_data_q  <= data_n;
			out_ovf_q   <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STORE_DEPTH))
		else $error("fill count beyond store depth");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SPLIT || state_q == ST_ZERO))
		else $error("store written outside edge sequencing");

	a_zero_follows_hi: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ZERO |-> $past(state_q) == ST_SPLIT)
		else $error("zero entry without preceding 0xFFFF entry");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> (fill_q == $past(fill_q) + FW'(1) || fill_q == '0))
		else $error("fill count jumped");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("result register overwritten while held");
`endif

endmodule
